FILE: src/ppnt_pkg.sv
// shared types and constants for the pressure pad note trigger
// no dependencies

package ppnt_pkg;

  localparam int SAMPLE_W  = 10;
  localparam int LEVEL_W   = 7;
  localparam int FLAT_W    = 11;
  localparam int STATUS_W  = 8;
  localparam int LIMIT_W   = 10;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam logic [LEVEL_W-1:0]  LEVEL_MAX = 7'd127;
  localparam logic [FLAT_W-1:0]   FLAT_SAT  = 11'd2047;

  localparam logic [LEVEL_W-1:0]  RST_NOTE       = 7'd60;
  localparam logic [STATUS_W-1:0] RST_STATUS     = 8'h90;
  localparam logic [LEVEL_W-1:0]  RST_MIN_VEL    = 7'd30;
  localparam logic [LEVEL_W-1:0]  RST_MARGIN     = 7'd10;
  localparam logic [LEVEL_W-1:0]  RST_FLAT_RANGE = 7'd20;
  localparam logic [LIMIT_W-1:0]  RST_FLAT_LIMIT = 10'd500;

  typedef enum logic [2:0] {
    REG_NOTE       = 3'd0,
    REG_STATUS     = 3'd1,
    REG_MIN_VEL    = 3'd2,
    REG_MARGIN     = 3'd3,
    REG_FLAT_RANGE = 3'd4,
    REG_FLAT_LIMIT = 3'd5
  } cfg_reg_t;

endpackage

FILE: src/ppnt_level.sv
// converts one sample into a 7-bit level: scaled converter reading or clipped velocity
// depends on ppnt_pkg

module ppnt_level import ppnt_pkg::*; #(
  parameter int ADC_BITS = 10
) (
  input  logic                mode,
  input  logic [SAMPLE_W-1:0] sample_value,
  output logic [LEVEL_W-1:0]  level
);

  localparam int PROD_W   = SAMPLE_W + LEVEL_W;
  localparam int WORK_W   = PROD_W + 1;
  localparam int RECIP_W  = PROD_W + 1;
  localparam int SHIFT    = PROD_W + ADC_BITS;
  localparam int MUL_W    = PROD_W + RECIP_W;
  localparam logic [63:0] FULL64      = (64'd1 << ADC_BITS) - 64'd1;
  localparam logic [63:0] RECIP_FULL  = (64'd1 << SHIFT) / FULL64;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
  localparam logic [WORK_W-1:0]  FULL  = FULL64[WORK_W-1:0];

  logic [WORK_W-1:0] prod;
  logic [MUL_W-1:0]  est_mul;
  logic [WORK_W-1:0] q_est;
  logic [WORK_W-1:0] back;
  logic [WORK_W-1:0] rem;
  logic [WORK_W-1:0] quot;

  // sample * 127 as shift and subtract
  assign prod    = ({{(WORK_W-SAMPLE_W){1'b0}}, sample_value} << LEVEL_W)
                 - {{(WORK_W-SAMPLE_W){1'b0}}, sample_value};
  assign est_mul = {{(MUL_W-WORK_W){1'b0}}, prod} * {{(MUL_W-RECIP_W){1'b0}}, RECIP};
  assign q_est   = WORK_W'(est_mul >> SHIFT);
  // q_est * (2^ADC_BITS - 1)
  assign back    = (q_est << ADC_BITS) - q_est;
  assign rem     = prod - back;
  assign quot    = (rem >= FULL) ? q_est + WORK_W'(1) : q_est;

  always_comb begin
    if (mode) begin
      level = (sample_value > {{(SAMPLE_W-LEVEL_W){1'b0}}, LEVEL_MAX}) ?
              LEVEL_MAX : sample_value[LEVEL_W-1:0];
    end else begin
      level = (quot > {{(WORK_W-LEVEL_W){1'b0}}, LEVEL_MAX}) ?
              LEVEL_MAX : quot[LEVEL_W-1:0];
    end
  end

endmodule

FILE: src/pressure_pad_note_trigger_core.sv
// top level of the pressure pad note trigger: config registers, level stage, strike logic
// depends on ppnt_pkg and ppnt_level

// One pressure sample is taken per clock while in_tready is high. Each sample is turned
// into a 7-bit level in a first register stage (scaling multiply in that path) and judged
// against the tracked level and flat count in a second stage that holds the result, and a
// full throughput of one sample per cycle is kept while the result side accepts. A stalled
// result holds both stages once the level stage is full. Configuration writes take effect
// from the next sample judged.

module pressure_pad_note_trigger_core import ppnt_pkg::*; #(
  parameter int ADC_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [9:0] sample_value, rest zero
  input  logic                  in_tuser,   // [0] mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] msg_status, [14:8] msg_note,
                                            // [21:15] msg_velocity, rest zero
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  logic [LEVEL_W-1:0]  note_r;
  logic [STATUS_W-1:0] status_r;
  logic [LEVEL_W-1:0]  min_vel_r;
  logic [LEVEL_W-1:0]  margin_r;
  logic [LEVEL_W-1:0]  flat_range_r;
  logic [LIMIT_W-1:0]  flat_limit_r;

  logic [LEVEL_W-1:0]  level;
  logic                lvl_valid_r;
  logic [LEVEL_W-1:0]  lvl_r;

  logic                active_r, active_nxt;
  logic [LEVEL_W-1:0]  last_r, last_nxt;
  logic [FLAT_W-1:0]   flat_r, flat_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0]  out_vel_r, out_vel_nxt;
  logic [LEVEL_W-1:0]  out_note_r;
  logic [STATUS_W-1:0] out_status_r;

  logic                adv;
  logic                cfg_wr;
  cfg_reg_t            cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_sel = cfg_reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      note_r       <= RST_NOTE;
      status_r     <= RST_STATUS;
      min_vel_r    <= RST_MIN_VEL;
      margin_r     <= RST_MARGIN;
      flat_range_r <= RST_FLAT_RANGE;
      flat_limit_r <= RST_FLAT_LIMIT;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_NOTE:       note_r       <= pwdata[LEVEL_W-1:0];
        REG_STATUS:     status_r     <= pwdata[STATUS_W-1:0];
        REG_MIN_VEL:    min_vel_r    <= pwdata[LEVEL_W-1:0];
        REG_MARGIN:     margin_r     <= pwdata[LEVEL_W-1:0];
        REG_FLAT_RANGE: flat_range_r <= pwdata[LEVEL_W-1:0];
        REG_FLAT_LIMIT: flat_limit_r <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_NOTE:       prdata = DATA_W'(note_r);
      REG_STATUS:     prdata = DATA_W'(status_r);
      REG_MIN_VEL:    prdata = DATA_W'(min_vel_r);
      REG_MARGIN:     prdata = DATA_W'(margin_r);
      REG_FLAT_RANGE: prdata = DATA_W'(flat_range_r);
      REG_FLAT_LIMIT: prdata = DATA_W'(flat_limit_r);
      default:        prdata = '0;
    endcase
  end

  ppnt_level #(.ADC_BITS(ADC_BITS)) u_level (
    .mode         (in_tuser),
    .sample_value (in_tdata[SAMPLE_W-1:0]),
    .level        (level)
  );

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !lvl_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      lvl_valid_r <= 1'b1;
    end else if (adv) begin
      lvl_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      lvl_r <= level;
    end
  end

  always_comb begin
    logic               thr_ok;
    logic [LEVEL_W-1:0] thr;
    logic [LEVEL_W-1:0] diff;
    logic [FLAT_W-1:0]  flat_inc;
    active_nxt    = active_r;
    last_nxt      = last_r;
    flat_nxt      = flat_r;
    out_valid_nxt = out_valid_r;
    out_vel_nxt   = out_vel_r;
    thr_ok        = min_vel_r > margin_r;
    thr           = min_vel_r - margin_r;
    diff          = lvl_r - last_r;
    flat_inc      = (flat_r < FLAT_SAT) ? flat_r + FLAT_W'(1) : flat_r;
    if (adv) begin
      out_valid_nxt = 1'b0;
      if (lvl_valid_r) begin
        if (active_r) begin
          if (thr_ok && lvl_r < thr) begin
            active_nxt    = 1'b0;
            out_valid_nxt = 1'b1;
            out_vel_nxt   = '0;
          end
        end else if (last_r > lvl_r) begin
          active_nxt    = 1'b1;
          last_nxt      = '0;
          flat_nxt      = '0;
          out_valid_nxt = 1'b1;
          out_vel_nxt   = lvl_r;
        end else if (lvl_r >= min_vel_r) begin
          if (diff < flat_range_r && flat_inc > FLAT_W'(flat_limit_r)) begin
            active_nxt    = 1'b1;
            last_nxt      = '0;
            flat_nxt      = '0;
            out_valid_nxt = 1'b1;
            out_vel_nxt   = lvl_r;
          end else begin
            if (diff < flat_range_r) begin
              flat_nxt = flat_inc;
            end
            last_nxt = lvl_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      last_r      <= '0;
      flat_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      last_r      <= last_nxt;
      flat_r      <= flat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && lvl_valid_r) begin
      out_vel_r    <= out_vel_nxt;
      out_note_r   <= note_r;
      out_status_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-STATUS_W-2*LEVEL_W){1'b0}},
                       out_vel_r, out_note_r, out_status_r};

endmodule

FILE: src/ppnt_checker.sv
// port-level checks for the pressure pad note trigger core, bound to the top level
// depends on ppnt_pkg and pressure_pad_note_trigger_core

module ppnt_checker import ppnt_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // empty result register never blocks the input side
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // pipeline drains when the input stays idle while the result side keeps accepting
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_tvalid && out_tready) ##1 (!in_tvalid && out_tready) |=> !out_tvalid)
    else $error("result appeared without a sample transfer");

endmodule

bind pressure_pad_note_trigger_core ppnt_checker u_ppnt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/ppnt_checker.sv
`timescale 1ns / 100ps
// checker for the pressure pad note trigger: watches sample, message and register transfers,
// predicts every message from its own copy of the pad state and compares it field by field
// depends on ppnt_pkg

module ppnt_scoreboard import ppnt_pkg::*; #(
  parameter int ADC_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output int                    fail_count,
  output int                    pending,
  output int                    note_ons,
  output int                    note_offs
);

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [LEVEL_W-1:0]  note;
    logic [LEVEL_W-1:0]  velocity;
  } note_msg_t;

  note_msg_t msg_q[$];

  logic [LEVEL_W-1:0]  note_num;
  logic [STATUS_W-1:0] status;
  logic [LEVEL_W-1:0]  min_vel;
  logic [LEVEL_W-1:0]  margin;
  logic [LEVEL_W-1:0]  flat_range;
  logic [LIMIT_W-1:0]  flat_limit;

  logic                playing;
  logic [LEVEL_W-1:0]  last_lvl;
  logic [FLAT_W-1:0]   flat_cnt;

  int fails;
  int ons;
  int offs;

  function automatic logic [LEVEL_W-1:0] pad_level(logic m, logic [SAMPLE_W-1:0] v);
    longint unsigned full;
    longint unsigned lvl;
    full = (longint'(1) << ADC_BITS) - 1;
    if (m)
      lvl = v;
    else
      lvl = (longint'(v) * 127) / full;
    if (lvl > LEVEL_MAX)
      lvl = LEVEL_MAX;
    return lvl[LEVEL_W-1:0];
  endfunction

  // one sample against the tracked level, flat count and playing flag
  task automatic judge_sample(input logic m, input logic [SAMPLE_W-1:0] v,
                              output logic fire, output logic [LEVEL_W-1:0] vel);
    logic [LEVEL_W-1:0] lvl;
    logic               struck;
    lvl    = pad_level(m, v);
    fire   = 1'b0;
    struck = 1'b0;
    vel    = '0;
    if (playing) begin
      if (min_vel > margin && lvl < min_vel - margin) begin
        playing = 1'b0;
        fire    = 1'b1;
        offs++;
      end
    end else if (last_lvl > lvl) begin
      struck = 1'b1;
    end else if (lvl >= min_vel) begin
      if (lvl - last_lvl < flat_range) begin
        if (flat_cnt < FLAT_SAT)
          flat_cnt++;
        if (flat_cnt > flat_limit)
          struck = 1'b1;
      end
      if (!struck)
        last_lvl = lvl;
    end
    if (struck) begin
      last_lvl = '0;
      flat_cnt = '0;
      playing  = 1'b1;
      fire     = 1'b1;
      vel      = lvl;
      ons++;
    end
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    logic               fire;
    logic [LEVEL_W-1:0] vel;
    note_msg_t          want;
    if (!rst_n) begin
      note_num   = RST_NOTE;
      status     = RST_STATUS;
      min_vel    = RST_MIN_VEL;
      margin     = RST_MARGIN;
      flat_range = RST_FLAT_RANGE;
      flat_limit = RST_FLAT_LIMIT;
      playing    = 1'b0;
      last_lvl   = '0;
      flat_cnt   = '0;
      msg_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_NOTE:       note_num   = pwdata[LEVEL_W-1:0];
          REG_STATUS:     status     = pwdata[STATUS_W-1:0];
          REG_MIN_VEL:    min_vel    = pwdata[LEVEL_W-1:0];
          REG_MARGIN:     margin     = pwdata[LEVEL_W-1:0];
          REG_FLAT_RANGE: flat_range = pwdata[LEVEL_W-1:0];
          REG_FLAT_LIMIT: flat_limit = pwdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        judge_sample(in_tuser, in_tdata[SAMPLE_W-1:0], fire, vel);
        if (fire)
          msg_q.push_back('{status, note_num, vel});
      end
      if (out_tvalid && out_tready) begin
        if (msg_q.size() == 0) begin
          $error("message transfer with nothing expected: %h", out_tdata);
          fails++;
        end else begin
          want = msg_q.pop_front();
          compare_field("msg_status", want.status, out_tdata[7:0]);
          compare_field("msg_note", want.note, out_tdata[14:8]);
          compare_field("msg_velocity", want.velocity, out_tdata[21:15]);
        end
      end
    end
    fail_count <= fails;
    pending    <= msg_q.size();
    note_ons   <= ons;
    note_offs  <= offs;
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// testbench top for the pressure pad note trigger: clock, reset, sample stimulus,
// register writes and the verdict; depends on ppnt_pkg, ppnt_scoreboard and the core

module tb_top import ppnt_pkg::*; ();

  localparam int         LIMIT       = 200000;
  localparam int         SETTLE      = 8;
  localparam int         PHASE_ITEMS = 75;
  localparam int         PHASES      = 6;
  localparam logic       MODE_RAW    = 1'b0;
  localparam logic       MODE_VEL    = 1'b1;
  localparam logic [2:0] REG_SPARE   = 3'd6;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [9:0] sample_value, rest zero
  logic                  in_tuser;   // [0] mode
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [7:0] msg_status, [14:8] msg_note, [21:15] msg_velocity
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [DATA_W-1:0]     pwdata;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  logic calm;
  int   n_sent;
  int   n_settings;
  int   cycles;
  int   fail_count;
  int   pending;
  int   note_ons;
  int   note_offs;

  pressure_pad_note_trigger_core #(.ADC_BITS(10)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  ppnt_scoreboard #(.ADC_BITS(10)) u_scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending),
    .note_ons   (note_ons),
    .note_offs  (note_offs)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 23);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_sample(input logic m, input logic [SAMPLE_W-1:0] v);
    while (!calm && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= IN_DATA_W'(v);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_sent++;
  endtask

  // a sample of a given level, either as velocity or as a converter reading
  task automatic send_level(input int lvl);
    int raw;
    if ($urandom_range(1)) begin
      raw = lvl;
      if (lvl == 127 && $urandom_range(1))
        raw = $urandom_range(1023, 127);
      send_sample(MODE_VEL, raw[SAMPLE_W-1:0]);
    end else begin
      raw = (lvl * 1023 + 126) / 127 + $urandom_range(3);
      if (raw > 1023)
        raw = 1023;
      send_sample(MODE_RAW, raw[SAMPLE_W-1:0]);
    end
  endtask

  // rise, plateau, drop, a few playing samples, then release
  task automatic play_hit();
    int peak;
    int steps;
    peak  = $urandom_range(127);
    steps = $urandom_range(5, 1);
    for (int i = 1; i <= steps; i++)
      send_level(peak * i / steps);
    repeat ($urandom_range(8)) send_level(peak);
    send_level($urandom_range(peak));
    repeat ($urandom_range(3)) send_level($urandom_range(127));
    repeat ($urandom_range(3, 1)) send_level($urandom_range(15));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_config(input int note, input int stat, input int minv,
                              input int marg, input int range, input int limit);
    reg_write(REG_NOTE, note);
    reg_write(REG_STATUS, stat);
    reg_write(REG_MIN_VEL, minv);
    reg_write(REG_MARGIN, marg);
    reg_write(REG_FLAT_RANGE, range);
    reg_write(REG_FLAT_LIMIT, limit);
    n_settings++;
  endtask

  function automatic int corner_pick(input int hi, input int typical);
    case ($urandom_range(5))
      0:       return 0;
      1:       return hi;
      default: return $urandom_range(typical);
    endcase
  endfunction

  initial begin
    int target;
    rst_n      <= 1'b0;
    calm       <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    n_settings = 1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: saturation, strike on drop, release, both modes
    send_sample(MODE_VEL, 10'd0);
    send_sample(MODE_VEL, 10'd1023);
    send_sample(MODE_VEL, 10'd100);
    send_sample(MODE_VEL, 10'd128);
    send_sample(MODE_VEL, 10'd19);
    send_sample(MODE_RAW, 10'd1023);
    send_sample(MODE_RAW, 10'd0);
    send_sample(MODE_RAW, 10'd160);
    send_sample(MODE_RAW, 10'd512);
    drain();

    // writes past the last register are ignored
    reg_write(REG_SPARE, '1);
    reg_write(REG_SPARE + 3'd1, '1);

    // flat-count strike, then a note that never ends
    write_config(127, 255, 0, 0, 127, 2);
    send_sample(MODE_VEL, 10'd70);
    send_sample(MODE_VEL, 10'd70);
    send_sample(MODE_VEL, 10'd70);
    send_sample(MODE_VEL, 10'd0);
    send_sample(MODE_RAW, 10'd0);
    drain();

    // highest release threshold, no flat range, largest flat limit
    write_config(0, 0, 127, 0, 0, 1023);
    send_sample(MODE_VEL, 10'd126);
    send_sample(MODE_VEL, 10'd1023);
    send_sample(MODE_RAW, 10'd1016);
    send_sample(MODE_RAW, 10'd1023);
    send_sample(MODE_VEL, 10'd5);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_config(corner_pick(127, 127), corner_pick(255, 255), corner_pick(127, 60),
                   corner_pick(127, 40), corner_pick(127, 40),
                   (ph == PHASES - 1) ? 1023 : corner_pick(1023, 24));
      calm   <= (ph == 2);
      target = n_sent + PHASE_ITEMS;
      while (n_sent < target) begin
        if ($urandom_range(9) < 7)
          play_hit();
        else
          repeat ($urandom_range(4, 1))
            send_sample(1'($urandom_range(1)), SAMPLE_W'($urandom_range(1023)));
      end
      drain();
    end

    $display("covered %0d samples under %0d register settings", n_sent, n_settings);
    $display("predicted %0d note-ons and %0d note-offs", note_ons, note_offs);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: pressure_pad_note_trigger_core.f
src/ppnt_pkg.sv
src/ppnt_level.sv
src/pressure_pad_note_trigger_core.sv
src/ppnt_checker.sv
tb/ppnt_checker.sv
tb/tb_top.sv
